// ===== hdl/png_mng_chunk_walker_assert.svh =====
// ----------------------------------------------------------------------------
// png_mng_chunk_walker_assert.svh
// Assertion macros used by the chunk walker's checker.
// ----------------------------------------------------------------------------
`ifndef PNG_MNG_CHUNK_WALKER_ASSERT_SVH
`define PNG_MNG_CHUNK_WALKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PMCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmcw assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PMCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmcw assertion failed");

`endif

// ===== hdl/pmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// pmcw_pkg
// Types and constants for the PNG / MNG chunk stream walker.
// ----------------------------------------------------------------------------
package pmcw_pkg;

    // Walk phases
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_HDR  = 3'd1,
        PH_SKIP = 3'd2,
        PH_DONE = 3'd3,
        PH_FAIL = 3'd4
    } t_phase;

    // Stream kind as reported on the result
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PNG  = 2'd1,
        KIND_MNG  = 2'd2
    } t_kind;

    // One input word held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Signature words and terminal chunk types, big-endian
    localparam logic [31:0] SIG_PNG_HEAD = 32'h8950_4E47;
    localparam logic [31:0] SIG_MNG_HEAD = 32'h8A4D_4E47;
    localparam logic [31:0] SIG_TAIL     = 32'h0D0A_1A0A;
    localparam logic [31:0] TYPE_IEND    = 32'h4945_4E44;
    localparam logic [31:0] TYPE_MEND    = 32'h4D45_4E44;

    // Largest stream length the result can carry
    localparam logic [33:0] MAX_IMAGE    = 34'h0_7FFF_FFFF;

    // Header's last byte + CRC, and the CRC alone, added to the data count
    localparam logic [33:0] HDR_TAIL_ADJ = 34'd5;
    localparam logic [31:0] CRC_BYTES    = 32'd4;

    // Case-folding mask for chunk type letters
    localparam logic [7:0]  CASE_MASK    = 8'hDF;

    // Chunk type byte test: a letter in either case
    function automatic logic is_letter(input logic [7:0] b);
        logic [7:0] u;
        u = b & CASE_MASK;
        return (u >= 8'h41) && (u <= 8'h5A);
    endfunction

endpackage

// ===== hdl/pmcw_in_stage.sv =====
// ----------------------------------------------------------------------------
// pmcw_in_stage
// Input register: holds one byte word until the walker takes it.
// ----------------------------------------------------------------------------
module pmcw_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pmcw_pkg::t_in_word i_word,
    input  logic              i_room,
    output logic              o_take,
    output pmcw_pkg::t_in_word o_word
);

    logic               r_valid;
    pmcw_pkg::t_in_word r_word;

    // Walker consumes the held word whenever its result side has room
    assign o_take  = r_valid && i_room;
    assign o_ready = !r_valid || i_room;
    assign o_word  = r_word;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

// ===== hdl/pmcw_walker.sv =====
// ----------------------------------------------------------------------------
// pmcw_walker
// Per-byte signature / chunk header walk and the result register.
// ----------------------------------------------------------------------------
module pmcw_walker #(
    parameter int LENGTH_BITS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  pmcw_pkg::t_in_word i_word,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic [1:0]         o_file_kind,
    output logic [30:0]        o_image_length
);

    localparam logic [32:0] LenLimit = 33'd1 << LENGTH_BITS;

    // Walk state
    pmcw_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_idx,   n_idx;
    logic [31:0]      r_len,   n_len;
    logic [31:0]      r_type,  n_type;
    logic [30:0]      r_skip,  n_skip;
    logic [31:0]      r_pos,   n_pos;
    pmcw_pkg::t_kind  r_kind,  n_kind;
    logic             r_term,  n_term;

    // Result register
    logic             r_out_valid;
    logic             r_found,  n_found;
    pmcw_pkg::t_kind  r_okind,  n_okind;
    logic [30:0]      r_olen,   n_olen;

    logic [31:0] pos_inc;
    logic [33:0] chunk_end;
    logic        letters_ok;
    logic [7:0]  b;

    assign o_room         = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_file_kind    = r_okind;
    assign o_image_length = r_olen;

    assign b          = i_word.data_byte;
    assign pos_inc    = r_pos + 32'd1;
    // End of the chunk's CRC: position after this byte plus data and CRC
    assign chunk_end  = {2'b00, r_pos} + {2'b00, r_len} + pmcw_pkg::HDR_TAIL_ADJ;
    assign letters_ok = pmcw_pkg::is_letter(r_type[23:16]) &&
                        pmcw_pkg::is_letter(r_type[15:8])  &&
                        pmcw_pkg::is_letter(r_type[7:0])   &&
                        pmcw_pkg::is_letter(b);

    // Next state for one byte
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_len   = r_len;
        n_type  = r_type;
        n_skip  = r_skip;
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_term  = r_term;

        unique case (r_phase)
            pmcw_pkg::PH_SIG, pmcw_pkg::PH_HDR: begin
                n_pos = pos_inc;
                n_idx = r_idx + 3'd1;
                if (!r_idx[2]) begin
                    n_len = {r_len[23:0], b};
                end else begin
                    n_type = {r_type[23:0], b};
                end
                if (r_idx == 3'd7) begin
                    if (r_phase == pmcw_pkg::PH_SIG) begin
                        // Signature check
                        priority if (n_type != pmcw_pkg::SIG_TAIL) begin
                            n_phase = pmcw_pkg::PH_FAIL;
                        end else if (r_len == pmcw_pkg::SIG_PNG_HEAD) begin
                            n_kind  = pmcw_pkg::KIND_PNG;
                            n_phase = pmcw_pkg::PH_HDR;
                        end else if (r_len == pmcw_pkg::SIG_MNG_HEAD) begin
                            n_kind  = pmcw_pkg::KIND_MNG;
                            n_phase = pmcw_pkg::PH_HDR;
                        end else begin
                            n_phase = pmcw_pkg::PH_FAIL;
                        end
                    end else begin
                        // Chunk header check
                        priority if (!letters_ok) begin
                            n_phase = pmcw_pkg::PH_FAIL;
                        end else if ({1'b0, r_len} >= LenLimit) begin
                            n_phase = pmcw_pkg::PH_FAIL;
                        end else if (chunk_end > pmcw_pkg::MAX_IMAGE) begin
                            n_phase = pmcw_pkg::PH_FAIL;
                        end else begin
                            n_term  = (r_kind == pmcw_pkg::KIND_PNG) ?
                                      (n_type == pmcw_pkg::TYPE_IEND) :
                                      (n_type == pmcw_pkg::TYPE_MEND);
                            n_skip  = 31'(r_len + pmcw_pkg::CRC_BYTES);
                            n_phase = pmcw_pkg::PH_SKIP;
                        end
                    end
                end
            end
            pmcw_pkg::PH_SKIP: begin
                n_pos  = pos_inc;
                n_skip = r_skip - 31'd1;
                if (r_skip == 31'd1) begin
                    n_phase = r_term ? pmcw_pkg::PH_DONE : pmcw_pkg::PH_HDR;
                end
            end
            pmcw_pkg::PH_DONE, pmcw_pkg::PH_FAIL: begin
            end
            default: begin
            end
        endcase

        // Verdict on the buffer's last byte
        n_found = (n_phase == pmcw_pkg::PH_DONE);
        n_okind = n_found ? n_kind : pmcw_pkg::KIND_NONE;
        n_olen  = n_found ? n_pos[30:0] : 31'd0;

        // Back to reset state for the next buffer
        if (i_word.last_byte) begin
            n_phase = pmcw_pkg::PH_SIG;
            n_idx   = 3'd0;
            n_len   = 32'd0;
            n_type  = 32'd0;
            n_skip  = 31'd0;
            n_pos   = 32'd0;
            n_kind  = pmcw_pkg::KIND_NONE;
            n_term  = 1'b0;
        end
    end

    // Walk state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pmcw_pkg::PH_SIG;
            r_idx   <= 3'd0;
            r_len   <= 32'd0;
            r_type  <= 32'd0;
            r_skip  <= 31'd0;
            r_pos   <= 32'd0;
            r_kind  <= pmcw_pkg::KIND_NONE;
            r_term  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_type  <= n_type;
            r_skip  <= n_skip;
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_term  <= n_term;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_take && i_word.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_take && i_word.last_byte) begin
            r_found <= n_found;
            r_okind <= n_okind;
            r_olen  <= n_olen;
        end
    end

endmodule

// ===== hdl/png_mng_chunk_walker.sv =====
// ----------------------------------------------------------------------------
// png_mng_chunk_walker
// PNG / MNG signature and chunk stream walker, one byte per word.
// ----------------------------------------------------------------------------
// Takes one byte word per clock, back to back. Each byte passes an input
// register and then the walk logic (signature match, chunk header decode,
// chunk skip counter), whose single add-and-compare on the chunk end sets
// the clock path. A result word is produced only for the byte marked last,
// registered when the walker takes that byte from the input register, and
// gives found, the stream kind and the length through the end of the IEND
// or MEND chunk. While a result waits for the receiver the walk pauses, so
// input stalls once the input register also holds a word. CRCs are not
// checked. LENGTH_BITS bounds the chunk length field that is accepted.
// ----------------------------------------------------------------------------
module png_mng_chunk_walker #(
    parameter int LENGTH_BITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [1:0]  o_file_kind,
    output logic [30:0] o_image_length
);

    pmcw_pkg::t_in_word in_word;
    pmcw_pkg::t_in_word held_word;
    logic               take;
    logic               room;

    assign in_word.data_byte = i_data_byte;
    assign in_word.last_byte = i_last_byte;

    // Input register
    pmcw_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .i_room  (room),
        .o_take  (take),
        .o_word  (held_word)
    );

    // Walk logic and result register
    pmcw_walker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_word         (held_word),
        .o_room         (room),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_file_kind    (o_file_kind),
        .o_image_length (o_image_length)
    );

endmodule

// ===== hdl/pmcw_checker.sv =====
// ----------------------------------------------------------------------------
// pmcw_checker
// Port-level checks on the chunk walker's result channel.
// ----------------------------------------------------------------------------
`include "png_mng_chunk_walker_assert.svh"

module pmcw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [1:0]  o_file_kind,
    input logic [30:0] o_image_length
);

    // A found stream names PNG or MNG
    `PMCW_ASSERT_NOW(a_found_kind, i_clk, i_rst_n, o_valid && o_found, (o_file_kind == pmcw_pkg::KIND_PNG) || (o_file_kind == pmcw_pkg::KIND_MNG))

    // A failed stream reports no kind and no length
    `PMCW_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && !o_found, (o_file_kind == pmcw_pkg::KIND_NONE) && (o_image_length == 31'd0))

    // Signature plus the smallest chunk is twenty bytes
    `PMCW_ASSERT_NOW(a_min_len, i_clk, i_rst_n, o_valid && o_found, o_image_length >= 31'd20)

    // A stalled result holds
    `PMCW_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_found) && $stable(o_file_kind) && $stable(o_image_length))

endmodule

bind png_mng_chunk_walker pmcw_checker u_pmcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_found        (o_found),
    .o_file_kind    (o_file_kind),
    .o_image_length (o_image_length)
);

// ===== tb/tb_png_mng_chunk_walker.sv =====
// ----------------------------------------------------------------------------
// tb_png_mng_chunk_walker
// Self-checking bench for the PNG / MNG chunk stream walker.
// ----------------------------------------------------------------------------
// Buffers are sent one byte word at a time. A directed set covers the
// signature and terminal chunk corners. Random buffers follow: mostly
// well-formed streams with random chunk content, the rest truncated,
// corrupted or plain noise. A local walk model predicts the verdict for
// every buffer. Each verdict from the block is compared field by field
// against the oldest prediction. Sender and receiver idle at random in
// two of three mixes; the third runs without idling. One phase holds the
// receiver off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_png_mng_chunk_walker;
    timeunit 1ns;
    timeprecision 1ps;

    import pmcw_pkg::*;

    localparam int LEN_BITS     = 31;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RX_HOLD_LEN  = 400;
    localparam int BYTES_PER_MIX = 190;
    localparam int FRAMES_PER_MIX = 3;
    localparam int HOLD_FRAMES  = 30;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } byte_word_t;

    typedef struct packed {
        logic        found;
        t_kind       kind;
        logic [30:0] length;
    } verdict_t;

    // DUT I/O, known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_last_byte    = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_found;
    logic [1:0]  o_file_kind;
    logic [30:0] o_image_length;

    // Stimulus and scoreboard storage
    byte_word_t  byte_backlog[$];
    verdict_t    verdicts_due[$];
    logic [7:0]  frame[$];
    int          hdr_at[$];

    // Run controls and counters
    int          src_idle_pct = 0;
    int          rx_idle_pct  = 0;
    logic        rx_hold_req  = 1'b0;
    logic        rx_hold_seen = 1'b0;
    int          rx_hold_cnt  = 0;
    int          mismatches   = 0;
    int          frames_sent  = 0;
    int          bytes_accepted = 0;
    int          verdicts_checked = 0;
    int          streams_found = 0;
    int          cycle_count  = 0;

    // Walk model state
    t_phase      w_phase = PH_SIG;
    logic [3:0]  w_idx   = '0;
    logic [31:0] w_len   = '0;
    logic [31:0] w_skip  = '0;
    logic [31:0] w_pos   = '0;
    t_kind       w_kind  = KIND_NONE;
    logic [31:0] w_type  = '0;
    logic        w_term  = 1'b0;

    png_mng_chunk_walker #(
        .LENGTH_BITS   (LEN_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_file_kind    (o_file_kind),
        .o_image_length (o_image_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Walk model
    // ------------------------------------------------------------------

    // Chunk type byte: a letter in either case
    function automatic logic type_char_ok(input logic [7:0] b);
        logic [7:0] folded;
        folded = b & 8'hDF;
        return (folded >= 8'h41) && (folded <= 8'h5A);
    endfunction

    function automatic void clear_walk();
        w_phase = PH_SIG;
        w_idx   = '0;
        w_len   = '0;
        w_skip  = '0;
        w_pos   = '0;
        w_kind  = KIND_NONE;
        w_type  = '0;
        w_term  = 1'b0;
    endfunction

    // Advance the walk by one byte; returns 1 when a verdict is due
    function automatic logic walk_byte(input logic [7:0] b, input logic is_last,
                                       output verdict_t v);
        logic [33:0] chunk_end;
        logic        letters;
        v = '0;
        if (w_phase == PH_SIG || w_phase == PH_HDR) begin
            w_pos = w_pos + 32'd1;
            if (w_idx < 4'd4)
                w_len = {w_len[23:0], b};
            else
                w_type = {w_type[23:0], b};
            w_idx = w_idx + 4'd1;
            if (w_idx >= 4'd8) begin
                w_idx = '0;
                if (w_phase == PH_SIG) begin
                    // signature: head word in w_len, tail word in w_type
                    if (w_type == SIG_TAIL && w_len == SIG_PNG_HEAD) begin
                        w_kind  = KIND_PNG;
                        w_phase = PH_HDR;
                    end else if (w_type == SIG_TAIL && w_len == SIG_MNG_HEAD) begin
                        w_kind  = KIND_MNG;
                        w_phase = PH_HDR;
                    end else begin
                        w_phase = PH_FAIL;
                    end
                end else begin
                    letters = type_char_ok(w_type[31:24]) && type_char_ok(w_type[23:16]) &&
                              type_char_ok(w_type[15:8])  && type_char_ok(w_type[7:0]);
                    chunk_end = {2'b00, w_pos} + {2'b00, w_len} + 34'd4;
                    if (!letters)
                        w_phase = PH_FAIL;
                    else if ({1'b0, w_len} >= (33'd1 << LEN_BITS))
                        w_phase = PH_FAIL;
                    else if (chunk_end > 34'h0_7FFF_FFFF)
                        w_phase = PH_FAIL;
                    else begin
                        w_term  = (w_kind == KIND_PNG) ? (w_type == TYPE_IEND)
                                                       : (w_type == TYPE_MEND);
                        w_skip  = w_len + 32'd4;
                        w_phase = PH_SKIP;
                    end
                end
            end
        end else if (w_phase == PH_SKIP) begin
            w_pos  = w_pos + 32'd1;
            w_skip = w_skip - 32'd1;
            if (w_skip == 32'd0)
                w_phase = w_term ? PH_DONE : PH_HDR;
        end

        if (!is_last)
            return 1'b0;

        if (w_phase == PH_DONE) begin
            v.found  = 1'b1;
            v.kind   = w_kind;
            v.length = w_pos[30:0];
        end
        clear_walk();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Buffer assembly
    // ------------------------------------------------------------------

    task automatic put_word32(input logic [31:0] w);
        frame.push_back(w[31:24]);
        frame.push_back(w[23:16]);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endtask

    task automatic put_sig(input t_kind k);
        put_word32((k == KIND_MNG) ? SIG_MNG_HEAD : SIG_PNG_HEAD);
        put_word32(SIG_TAIL);
    endtask

    // Header plus 'body' random bytes (data and CRC, possibly cut short)
    task automatic put_chunk(input logic [31:0] len, input logic [31:0] typ,
                             input int body);
        hdr_at.push_back(frame.size());
        put_word32(len);
        put_word32(typ);
        repeat (body) frame.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] letter_type();
        logic [31:0] t;
        for (int i = 0; i < 4; i++)
            t[i*8 +: 8] = 8'h41 + 8'($urandom_range(0, 25)) + (8'($urandom_range(0, 1)) << 5);
        return t;
    endfunction

    // Move the assembled buffer into the backlog, last flag on its final byte
    task automatic ship_frame();
        byte_word_t w;
        for (int i = 0; i < frame.size(); i++) begin
            w.data    = frame[i];
            w.is_last = (i == frame.size() - 1);
            byte_backlog.push_back(w);
        end
        frame.delete();
        hdr_at.delete();
        frames_sent++;
    endtask

    // Mostly well-formed stream; about 30% get broken afterwards
    task automatic random_frame();
        t_kind       k;
        logic [31:0] term_type;
        logic [7:0]  nb;
        int          len;
        int          pick;
        int          at;
        k = ($urandom_range(0, 1) == 0) ? KIND_PNG : KIND_MNG;
        put_sig(k);
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            put_chunk(len, letter_type(), len + 4);
        end
        term_type = (k == KIND_PNG) ? TYPE_IEND : TYPE_MEND;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            term_type = (k == KIND_PNG) ? TYPE_MEND : TYPE_IEND;
        else if (pick == 1)
            term_type = term_type | 32'h2000_0000;
        len = $urandom_range(0, 8);
        put_chunk(len, term_type, len + 4);
        repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));

        if ($urandom_range(0, 99) >= 70) begin
            case ($urandom_range(0, 5))
                0: begin
                    // cut the buffer short
                    at = $urandom_range(1, frame.size());
                    while (frame.size() > at) void'(frame.pop_back());
                end
                1: begin
                    at = $urandom_range(0, frame.size() - 1);
                    frame[at] = 8'($urandom);
                end
                2: begin
                    at = $urandom_range(0, frame.size() - 1);
                    frame[at] = frame[at] ^ (8'h01 << $urandom_range(0, 7));
                end
                3: begin
                    frame.delete();
                    repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
                end
                4: begin
                    // length word with its top bit set
                    at = hdr_at[$urandom_range(0, hdr_at.size() - 1)];
                    frame[at] = frame[at] | 8'h80;
                end
                default: begin
                    // non-letter in a chunk type
                    at = hdr_at[$urandom_range(0, hdr_at.size() - 1)] + 4 + $urandom_range(0, 3);
                    do nb = 8'($urandom); while (type_char_ok(nb));
                    frame[at] = nb;
                end
            endcase
        end
        ship_frame();
    endtask

    // Sender pause: everything accepted, every verdict back, block settled
    task automatic wait_drained();
        while (byte_backlog.size() != 0 || i_valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got 0x%08h expected 0x%08h (verdict %0d)",
                 what, got, want, verdicts_checked);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers backlog words, predicts on each accepted word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        verdict_t   v;
        byte_word_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                bytes_accepted++;
                if (walk_byte(i_data_byte, i_last_byte, v))
                    verdicts_due.push_back(v);
            end
            if (!i_valid || o_ready) begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt = byte_backlog.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_last_byte <= nxt.is_last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, or a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            i_ready     <= 1'b0;
        end else if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_cnt  <= RX_HOLD_LEN;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: compare each verdict word against the oldest prediction
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected verdict", 32'(o_image_length), 32'd0);
            end else begin
                want = verdicts_due.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", 32'(o_found), 32'(want.found));
                if (o_file_kind !== want.kind)
                    report_mismatch("file_kind", 32'(o_file_kind), 32'(want.kind));
                if (o_image_length !== want.length)
                    report_mismatch("image_length", 32'(o_image_length), 32'(want.length));
            end
            if (o_found === 1'b1)
                streams_found++;
            verdicts_checked++;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d verdicts still due",
                 cycle_count, verdicts_due.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int mix_bytes;
        int mix_frames;
        int queued;
        src_idle_pct = 18;
        rx_idle_pct  = 47;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Minimal PNG and MNG streams
        put_sig(KIND_PNG);
        put_chunk(32'd0, TYPE_IEND, 4);
        ship_frame();
        put_sig(KIND_MNG);
        put_chunk(32'd0, TYPE_MEND, 4);
        ship_frame();
        // Header chunk with all-0xFF data, then terminal, then trailing bytes
        put_sig(KIND_PNG);
        hdr_at.push_back(frame.size());
        put_word32(32'd13);
        put_word32(32'h4948_4452);
        repeat (17) frame.push_back(8'hFF);
        put_chunk(32'd0, TYPE_IEND, 4);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        frame.push_back(8'h5A);
        ship_frame();
        // Buffers shorter than the signature
        frame.push_back(8'h00);
        ship_frame();
        frame.push_back(8'hFF);
        ship_frame();
        put_sig(KIND_PNG);
        void'(frame.pop_back());
        ship_frame();
        // Bad signature tail byte, then valid-looking chunks that are ignored
        put_sig(KIND_PNG);
        frame[7] = 8'h0B;
        put_chunk(32'd0, TYPE_IEND, 4);
        ship_frame();
        // Non-letter type byte
        put_sig(KIND_PNG);
        put_chunk(32'd1, 32'h4948_4052, 5);
        put_chunk(32'd0, TYPE_IEND, 4);
        ship_frame();
        // Length word with bit 31 set
        put_sig(KIND_MNG);
        put_chunk(32'h8000_0000, letter_type(), 2);
        ship_frame();
        // Chunk end just past the largest length, and exactly at it (then cut off)
        put_sig(KIND_PNG);
        put_chunk(32'h7FFF_FFEC, letter_type(), 2);
        ship_frame();
        put_sig(KIND_PNG);
        put_chunk(32'h7FFF_FFEB, letter_type(), 2);
        ship_frame();
        // Chunk header cut off
        put_sig(KIND_MNG);
        put_word32(32'd0);
        frame.push_back(8'h4D);
        ship_frame();
        // Wrong-kind and wrong-case terminals are ordinary chunks
        put_sig(KIND_PNG);
        put_chunk(32'd0, TYPE_MEND, 4);
        put_chunk(32'd0, 32'h6945_4E44, 4);
        ship_frame();
        put_sig(KIND_MNG);
        put_chunk(32'd2, TYPE_IEND, 6);
        put_chunk(32'd3, TYPE_MEND, 7);
        ship_frame();
        // Buffer ending inside the terminal chunk's CRC
        put_sig(KIND_PNG);
        put_chunk(32'd0, TYPE_IEND, 3);
        ship_frame();
        wait_drained();

        // Random buffers under three idling mixes
        for (int mix = 0; mix < 3; mix++) begin
            src_idle_pct = (mix == 0) ? 18 : (mix == 1) ? 47 : 0;
            rx_idle_pct  = (mix == 0) ? 47 : (mix == 1) ? 18 : 0;
            mix_bytes  = 0;
            mix_frames = 0;
            while (mix_bytes < BYTES_PER_MIX || mix_frames < FRAMES_PER_MIX) begin
                queued = byte_backlog.size();
                random_frame();
                mix_bytes = mix_bytes + byte_backlog.size() - queued;
                mix_frames++;
                // keep the backlog short so idling applies across the mix
                while (byte_backlog.size() > 64) @(negedge i_clk);
            end
            wait_drained();
        end

        // Back-pressure: long receiver hold while short buffers keep coming
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        rx_hold_req  = ~rx_hold_req;
        for (int i = 0; i < HOLD_FRAMES; i++) begin
            if (i % 6 == 0) begin
                put_sig((i % 12 == 0) ? KIND_PNG : KIND_MNG);
                put_chunk(32'd0, (i % 12 == 0) ? TYPE_IEND : TYPE_MEND, 4);
            end else begin
                repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
            end
            ship_frame();
        end
        wait_drained();

        $display("covered %0d buffers, %0d byte words, %0d verdicts checked",
                 frames_sent, bytes_accepted, verdicts_checked);
        $display("%0d complete streams found, %0d mismatches", streams_found, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
